// File: rtl/tkd_pkg.sv
// Shared types and constants for the terminal key decoder.
// No dependencies; imported by the core and its checker.
`default_nettype none

package tkd_pkg;

    // Width of one key code item.
    localparam int KEY_CODE_W = 9;

    typedef logic [KEY_CODE_W-1:0] t_key_code;
    typedef logic [7:0]            t_byte;

    // Arrow key codes.
    localparam t_key_code CODE_UP    = 9'd256;
    localparam t_key_code CODE_DOWN  = 9'd257;
    localparam t_key_code CODE_LEFT  = 9'd258;
    localparam t_key_code CODE_RIGHT = 9'd259;

    // Control bytes with a fixed meaning.
    localparam t_byte BYTE_NUL        = 8'd0;
    localparam t_byte BYTE_CTRL_A     = 8'd1;
    localparam t_byte BYTE_ACK        = 8'd6;
    localparam t_byte BYTE_BS         = 8'd8;
    localparam t_byte BYTE_LF         = 8'd10;
    localparam t_byte BYTE_VT         = 8'd11;
    localparam t_byte BYTE_FF         = 8'd12;
    localparam t_byte BYTE_ESC        = 8'd27;
    localparam t_byte BYTE_FS         = 8'd28;
    localparam t_byte BYTE_GS         = 8'd29;
    localparam t_byte BYTE_RS         = 8'd30;
    localparam t_byte BYTE_US         = 8'd31;
    localparam t_byte BYTE_LAST_CTRL  = 8'd31;

    // Printable bytes that matter inside an escape sequence.
    localparam t_byte CHAR_DIGIT_0    = 8'h30;
    localparam t_byte CHAR_DIGIT_9    = 8'h39;
    localparam t_byte CHAR_SEMICOLON  = 8'h3B;
    localparam t_byte CHAR_QUESTION   = 8'h3F;
    localparam t_byte CHAR_A          = 8'h41;
    localparam t_byte CHAR_B          = 8'h42;
    localparam t_byte CHAR_C          = 8'h43;
    localparam t_byte CHAR_D          = 8'h44;
    localparam t_byte CHAR_O          = 8'h4F;
    localparam t_byte CHAR_BRACKET    = 8'h5B;

endpackage

`default_nettype wire

// File: rtl/terminal_key_decoder_core.sv
// Terminal key decoder core: keyboard bytes in, key codes out.
// Depends on tkd_pkg for key codes and byte constants.
//
// Usage:
// - Input channel: i_valid, i_key_byte, o_stall. One byte is taken at each
//   rising edge with i_valid high and o_stall low.
// - Output channel: o_valid, o_key_code, i_stall. One key code leaves at each
//   rising edge with o_valid high and i_stall low. A byte gives zero or one
//   key code; zero bytes and the bytes that open or continue an escape sequence give nothing.
// - Config channel: i_cfg_valid, i_cfg_swap_arrows, o_cfg_ready. Ready is
//   always high; write only while the block is idle.
// The decode result is registered in the output register, or in the skid
// register while the output is stalled. Throughput is one byte per cycle while
// o_stall is low, set by the single decode stage feeding the output register.
// When the receiver stalls, the output register holds its item and one more
// item lands in a skid register; o_stall then rises until the skid drains.
// Reset clears the sequence state, the swap setting and the valid flags of
// both output registers; no item is pending after reset.
`default_nettype none

module terminal_key_decoder_core
    import tkd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // Input byte channel
    input  wire logic      i_valid,
    input  wire t_byte     i_key_byte,
    output logic           o_stall,
    // Output key channel
    output logic           o_valid,
    output t_key_code      o_key_code,
    input  wire logic      i_stall,
    // Configuration write channel
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_swap_arrows,
    output logic           o_cfg_ready
);

    logic      r_swap_arrows;
    logic      r_in_seq;
    logic      r_just_opened;
    logic      r_out_valid;
    t_key_code r_out_code;
    logic      r_skid_valid;
    t_key_code r_skid_code;

    logic      n_in_seq;
    logic      n_just_opened;
    logic      n_emit;
    t_key_code n_code;
    logic      fall_through;
    logic      in_accept;
    logic      out_accept;

    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_valid && !i_stall;

    // Decode one byte against the current sequence state.
    always_comb begin
        n_in_seq      = r_in_seq;
        n_just_opened = r_just_opened;
        n_emit        = 1'b0;
        n_code        = {1'b0, i_key_byte};
        fall_through  = 1'b0;
        if (i_key_byte == BYTE_NUL) begin
            fall_through = 1'b0;
        end else if (!r_in_seq && (i_key_byte > BYTE_LAST_CTRL)) begin
            n_emit = 1'b1;
        end else begin
            case (i_key_byte)
                BYTE_RS: begin
                    n_emit = 1'b1;
                    n_code = r_swap_arrows ? CODE_DOWN : CODE_UP;
                end
                BYTE_US: begin
                    n_emit = 1'b1;
                    n_code = r_swap_arrows ? CODE_UP : CODE_DOWN;
                end
                BYTE_VT, CHAR_A: begin
                    n_emit = 1'b1;
                    n_code = CODE_UP;
                end
                BYTE_LF, CHAR_B: begin
                    n_emit = 1'b1;
                    n_code = CODE_DOWN;
                end
                BYTE_ACK, BYTE_FF, BYTE_FS, CHAR_C: begin
                    n_emit = 1'b1;
                    n_code = CODE_RIGHT;
                end
                BYTE_CTRL_A, BYTE_BS, BYTE_GS, CHAR_D: begin
                    n_emit = 1'b1;
                    n_code = CODE_LEFT;
                end
                BYTE_ESC: begin
                    n_in_seq      = 1'b1;
                    n_just_opened = 1'b1;
                end
                CHAR_SEMICOLON, CHAR_QUESTION: begin
                    n_just_opened = 1'b0;
                end
                CHAR_O, CHAR_BRACKET: begin
                    if (r_just_opened) begin
                        n_just_opened = 1'b0;
                    end else begin
                        fall_through = 1'b1;
                    end
                end
                default: begin
                    if ((i_key_byte >= CHAR_DIGIT_0) && (i_key_byte <= CHAR_DIGIT_9)) begin
                        n_just_opened = 1'b0;
                    end else begin
                        fall_through = 1'b1;
                    end
                end
            endcase
            // An unhandled byte passes through when idle, else ends the sequence.
            if (fall_through) begin
                if (!r_in_seq) begin
                    n_emit = 1'b1;
                end else begin
                    n_in_seq      = 1'b0;
                    n_just_opened = 1'b0;
                end
            end
        end
        // Every emitted key leaves the decoder idle.
        if (n_emit) begin
            n_in_seq      = 1'b0;
            n_just_opened = 1'b0;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap_arrows <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_swap_arrows <= i_cfg_swap_arrows;
        end
    end

    // Sequence state advances on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seq      <= 1'b0;
            r_just_opened <= 1'b0;
        end else if (in_accept) begin
            r_in_seq      <= n_in_seq;
            r_just_opened <= n_just_opened;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_accept) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept && n_emit;
            end
        end else if (in_accept && n_emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_accept) begin
            r_out_code <= r_skid_valid ? r_skid_code : n_code;
        end else if (in_accept && n_emit) begin
            r_skid_code <= n_code;
        end
    end

    assign o_stall     = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_key_code  = r_out_code;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: rtl/tkd_checker.sv
// Port-level checker for the terminal key decoder core, bound to terminal_key_decoder_core.
// Depends on tkd_pkg and terminal_key_decoder_core.
`default_nettype none

module tkd_checker
    import tkd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire t_byte     i_key_byte,
    input wire logic      o_stall,
    input wire logic      o_valid,
    input wire t_key_code o_key_code,
    input wire logic      i_stall
);

    // A stalled key code holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_code))
        else $error("stalled key code changed or dropped");

    // Reset leaves nothing pending on either side.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("item pending after reset");

    // Back-pressure only when the output register is also full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output empty");

    // Key codes are nonzero and no greater than the last arrow code.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_code != 9'd0) && (o_key_code <= CODE_RIGHT))
        else $error("key code out of range");

    // A zero byte into an empty output gives no item.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_key_byte == BYTE_NUL) && !o_valid |=> !o_valid)
        else $error("zero byte produced a key code");

endmodule

bind terminal_key_decoder_core tkd_checker u_tkd_checker (.*);

`default_nettype wire
